/* rtl/sorted_char_table_with_vowel_pass_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted character table.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SORTED_CHAR_TABLE_WITH_VOWEL_PASS_UNIT_DEFINES_SVH
`define SORTED_CHAR_TABLE_WITH_VOWEL_PASS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCVP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scvp_pkg.sv */
// ----------------------------------------------------------------------------
// scvp_pkg
// Types, codes and helper functions shared by the sorted character table.
// ----------------------------------------------------------------------------
package scvp_pkg;

    localparam int DEPTH_DEFAULT = 32;

    typedef logic signed [7:0] char_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SWAP   = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef struct packed {
        cmd_t  command;
        char_t char_in;
    } req_t;

    typedef struct packed {
        char_t   char_out;
        logic    last;
        status_t status;
    } rsp_t;

    typedef struct packed {
        logic  wr_en;
        logic  wr_prev;
        char_t wr_data;
        char_t hold_next;
        logic  found_next;
    } step_ctl_t;

    localparam char_t CHAR_A = 8'sh61;
    localparam char_t CHAR_E = 8'sh65;
    localparam char_t CHAR_I = 8'sh69;
    localparam char_t CHAR_O = 8'sh6F;
    localparam char_t CHAR_U = 8'sh75;

    function automatic logic is_vowel(input char_t c);
        return (c == CHAR_A) || (c == CHAR_E) || (c == CHAR_I) ||
               (c == CHAR_O) || (c == CHAR_U);
    endfunction

endpackage

/* rtl/scvp_step_unit.sv */
// ----------------------------------------------------------------------------
// scvp_step_unit
// Shared compare unit for one step of a table walk: decides the write and the
// held value for an insert or a vowel swap pass.
// ----------------------------------------------------------------------------
module scvp_step_unit
(
    input  scvp_pkg::cmd_t      command,
    input  logic                first,
    input  logic                at_end,
    input  logic                found,
    input  scvp_pkg::char_t     entry,
    input  scvp_pkg::char_t     hold,
    input  scvp_pkg::char_t     char_new,
    output scvp_pkg::step_ctl_t ctl
);

    logic entry_lt;
    logic entry_eq;
    logic place_here;
    logic do_swap;

    assign entry_lt   = entry < char_new;
    assign entry_eq   = entry == char_new;
    assign place_here = first ? (!entry_lt && !entry_eq) : !entry_lt;
    assign do_swap    = scvp_pkg::is_vowel(hold) && !scvp_pkg::is_vowel(entry);

    always_comb
    begin
        ctl            = '0;
        ctl.hold_next  = hold;
        ctl.found_next = found;
        case (command)
            scvp_pkg::CMD_INSERT:
            begin
                if (at_end)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_data = found ? hold : char_new;
                end
                else if (found)
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.wr_data   = hold;
                    ctl.hold_next = entry;
                end
                else if (place_here)
                begin
                    ctl.wr_en      = 1'b1;
                    ctl.wr_data    = char_new;
                    ctl.hold_next  = entry;
                    ctl.found_next = 1'b1;
                end
            end
            scvp_pkg::CMD_SWAP:
            begin
                if (at_end)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_prev = 1'b1;
                    ctl.wr_data = hold;
                end
                else if (first)
                begin
                    ctl.hold_next = entry;
                end
                else if (do_swap)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_prev = 1'b1;
                    ctl.wr_data = entry;
                end
                else
                begin
                    ctl.wr_en     = 1'b1;
                    ctl.wr_prev   = 1'b1;
                    ctl.wr_data   = hold;
                    ctl.hold_next = entry;
                end
            end
            default:
            begin
                ctl.wr_en = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/scvp_out_reg.sv */
// ----------------------------------------------------------------------------
// scvp_out_reg
// Output register for the response channel with valid and ready.
// ----------------------------------------------------------------------------
module scvp_out_reg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  scvp_pkg::rsp_t load_data,
    output logic           free,
    output logic           valid,
    input  logic           ready,
    output scvp_pkg::rsp_t data
);

    logic           valid_reg;
    logic           valid_next;
    scvp_pkg::rsp_t data_reg;

    assign free       = !valid_reg || ready;
    assign valid_next = load ? 1'b1 : (ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* rtl/sorted_char_table_with_vowel_pass_unit.sv */
// ----------------------------------------------------------------------------
// sorted_char_table_with_vowel_pass_unit
// Bounded table of signed characters with insert, vowel swap pass, dump and
// clear commands, walked one entry per cycle by a sequencer; a dump can stall.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    scvp_pkg::req_t
//   rsp       out        rsp_valid/rsp_ready    scvp_pkg::rsp_t
//
// An insert or swap pass walks every entry before its response; the table
// memory is read and written once per cycle.
// A dump emits one response per cycle while rsp_ready stays high.
// Full-table insert, clear, empty dump and short swap passes skip the walk.
// Reset empties the table at once; memory contents need no clearing.
// The block accepts no request while one is in work.
// ----------------------------------------------------------------------------
module sorted_char_table_with_vowel_pass_unit
#(
    parameter int DEPTH = scvp_pkg::DEPTH_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  scvp_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output scvp_pkg::rsp_t rsp
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    scvp_pkg::state_t    state_reg, state_next;
    scvp_pkg::cmd_t      cmd_reg, cmd_next;
    scvp_pkg::char_t     char_reg, char_next;
    scvp_pkg::status_t   status_reg, status_next;
    scvp_pkg::char_t     hold_reg, hold_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;

    scvp_pkg::char_t     mem [DEPTH];
    scvp_pkg::char_t     rd_data_reg;
    logic [CNT_W-1:0]    rd_pos;
    logic [ADDR_W-1:0]   rd_idx;
    logic [CNT_W-1:0]    wr_pos;
    logic [ADDR_W-1:0]   wr_idx;
    logic                mem_we;

    scvp_pkg::step_ctl_t step;
    logic                at_end;
    logic                slot_free;
    logic                rsp_load;
    scvp_pkg::rsp_t      rsp_data;

    assign at_end = idx_reg == count_reg;

    scvp_step_unit u_step
    (
        .command  (cmd_reg),
        .first    (idx_reg == '0),
        .at_end   (at_end),
        .found    (found_reg),
        .entry    (rd_data_reg),
        .hold     (hold_reg),
        .char_new (char_reg),
        .ctl      (step)
    );

    scvp_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (rsp_load),
        .load_data (rsp_data),
        .free      (slot_free),
        .valid     (rsp_valid),
        .ready     (rsp_ready),
        .data      (rsp)
    );

    assign wr_pos = step.wr_prev ? (idx_reg - CNT_W'(1)) : idx_reg;
    assign wr_idx = wr_pos[ADDR_W-1:0];
    assign rd_idx = (rd_pos < CNT_W'(DEPTH)) ? rd_pos[ADDR_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= step.wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scvp_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        char_reg   <= char_next;
        status_reg <= status_next;
        hold_reg   <= hold_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        char_next   = char_reg;
        status_next = status_reg;
        hold_next   = hold_reg;
        found_next  = found_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rd_pos      = '0;
        mem_we      = 1'b0;
        req_ready   = 1'b0;
        rsp_load    = 1'b0;
        rsp_data    = '0;
        unique case (state_reg)
            scvp_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next    = req.command;
                    char_next   = req.char_in;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = scvp_pkg::STATUS_OK;
                    unique case (req.command)
                        scvp_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = scvp_pkg::STATUS_FULL;
                                state_next  = scvp_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = scvp_pkg::ST_WALK;
                            end
                        end
                        scvp_pkg::CMD_SWAP:
                        begin
                            state_next = (count_reg < CNT_W'(2)) ? scvp_pkg::ST_RESP
                                                                  : scvp_pkg::ST_WALK;
                        end
                        scvp_pkg::CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = scvp_pkg::STATUS_EMPTY;
                                state_next  = scvp_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = scvp_pkg::ST_WALK;
                            end
                        end
                        scvp_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = scvp_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            scvp_pkg::ST_WALK:
            begin
                if (cmd_reg == scvp_pkg::CMD_DUMP)
                begin
                    rd_pos = idx_reg;
                    if (slot_free)
                    begin
                        rsp_load          = 1'b1;
                        rsp_data.char_out = rd_data_reg;
                        rsp_data.last     = (idx_reg + CNT_W'(1)) == count_reg;
                        rsp_data.status   = scvp_pkg::STATUS_OK;
                        idx_next          = idx_reg + CNT_W'(1);
                        rd_pos            = idx_next;
                        if (rsp_data.last)
                        begin
                            state_next = scvp_pkg::ST_IDLE;
                        end
                    end
                end
                else
                begin
                    mem_we     = step.wr_en;
                    hold_next  = step.hold_next;
                    found_next = step.found_next;
                    idx_next   = idx_reg + CNT_W'(1);
                    rd_pos     = idx_next;
                    if (at_end)
                    begin
                        state_next = scvp_pkg::ST_RESP;
                        if (cmd_reg == scvp_pkg::CMD_INSERT)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            scvp_pkg::ST_RESP:
            begin
                if (slot_free)
                begin
                    rsp_load        = 1'b1;
                    rsp_data.last   = 1'b1;
                    rsp_data.status = status_reg;
                    state_next      = scvp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scvp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/scvp_checker.sv */
// ----------------------------------------------------------------------------
// scvp_checker
// Port-level checks for the sorted character table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_char_table_with_vowel_pass_unit_defines.svh"

module scvp_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input scvp_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input scvp_pkg::rsp_t rsp
);

    logic req_fire;
    logic stall;
    logic rsp_empty;
    logic rsp_full;
    logic tail_ok;

    assign req_fire  = req_valid && req_ready;
    assign stall     = rsp_valid && !rsp_ready;
    assign rsp_empty = rsp_valid && (rsp.status == scvp_pkg::STATUS_EMPTY);
    assign rsp_full  = rsp_valid && (rsp.status == scvp_pkg::STATUS_FULL);
    assign tail_ok   = rsp.last && (rsp.char_out == '0);

    `SCVP_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_fire, !req_ready, "accepted while busy")

    `SCVP_ASSERT_NEXT(a_rsp_hold, clk, rst_n, stall, rsp_valid && $stable(rsp), "rsp changed")

    `SCVP_ASSERT_SAME(a_empty_form, clk, rst_n, rsp_empty, tail_ok, "empty response malformed")

    `SCVP_ASSERT_SAME(a_full_form, clk, rst_n, rsp_full, tail_ok, "full response malformed")

endmodule

bind sorted_char_table_with_vowel_pass_unit scvp_checker u_scvp_checker (.*);
